>>> sv/mrbmv_pkg.sv
// Shared types and constants for the multi-read bit majority voter.
// Depends on nothing; mrbmv_vote and the top level use it.
`default_nettype none

package mrbmv_pkg;

    localparam int BITS_W              = 16;
    localparam int ONES_W              = $clog2(BITS_W + 1);
    localparam int CFG_W               = 5;
    localparam int COUNT_FIELD_W       = 20;
    localparam int MAX_REVOLUTIONS_DEF = 16;
    localparam int COUNT_WIDTH_DEF     = 20;
    localparam int NIBBLES             = BITS_W / 4;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    typedef logic [CFG_W-1:0] cfg_word_t;

    typedef struct packed {
        logic [BITS_W-1:0] revision_bits;
        logic              last_position;
    } in_word_t;

    typedef struct packed {
        logic                     majority_bit;
        logic                     weak_flag;
        logic [COUNT_FIELD_W-1:0] bits_seen;
        logic [COUNT_FIELD_W-1:0] unanimous_count;
        logic [COUNT_FIELD_W-1:0] weak_count;
        logic                     track_done;
    } out_word_t;

    typedef struct packed {
        logic majority;
        logic disagree;
    } vote_t;

endpackage

`default_nettype wire

>>> sv/mrbmv_chan_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Depends on nothing; payload types come from mrbmv_pkg at instantiation.
`default_nettype none

interface mrbmv_chan_if #(
    parameter type word_t = logic
);

    logic  valid;
    logic  ready;
    word_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

`default_nettype wire

>>> sv/mrbmv_vote.sv
// Majority vote over the revolutions in use at one bit position.
// Depends on mrbmv_pkg.
`default_nettype none

module mrbmv_vote #(
    parameter int MAX_REVOLUTIONS = mrbmv_pkg::MAX_REVOLUTIONS_DEF
) (
    input  wire logic [mrbmv_pkg::BITS_W-1:0] revision_bits,
    input  wire logic [mrbmv_pkg::CFG_W-1:0]  revisions_in_use,
    output mrbmv_pkg::vote_t                  vote
);

    localparam int NW = $clog2(MAX_REVOLUTIONS + 1);
    localparam int OW = mrbmv_pkg::ONES_W;
    localparam int SW = ((NW > OW) ? NW : OW) + 1;

    logic [NW-1:0]                    n_eff;
    logic [mrbmv_pkg::BITS_W-1:0]     used;
    logic [2:0]                       nib_cnt [mrbmv_pkg::NIBBLES];
    logic [OW-1:0]                    ones;
    logic [SW-1:0]                    two_ones;
    logic [SW-1:0]                    n_wide;

    always_comb
    begin
        if (int'(revisions_in_use) > MAX_REVOLUTIONS)
        begin
            n_eff = NW'(MAX_REVOLUTIONS);
        end
        else
        begin
            n_eff = NW'(revisions_in_use);
        end
    end

    assign n_wide = SW'(n_eff);

    always_comb
    begin
        for (int r = 0; r < mrbmv_pkg::BITS_W; r++)
        begin
            used[r] = revision_bits[r] && (SW'(r) < n_wide);
        end
    end

    always_comb
    begin
        for (int k = 0; k < mrbmv_pkg::NIBBLES; k++)
        begin
            nib_cnt[k] = 3'(used[4*k]) + 3'(used[4*k+1])
                       + 3'(used[4*k+2]) + 3'(used[4*k+3]);
        end
    end

    always_comb
    begin
        ones = '0;
        for (int k = 0; k < mrbmv_pkg::NIBBLES; k++)
        begin
            ones = ones + OW'(nib_cnt[k]);
        end
    end

    assign two_ones = SW'({ones, 1'b0});

    always_comb
    begin
        vote.majority = two_ones > n_wide;
        vote.disagree = (ones != '0) && (SW'(ones) != n_wide);
    end

endmodule

`default_nettype wire

>>> sv/multi_read_bit_majority_voter.sv
// Top level of the multi-read bit majority voter: input stage, vote, counters, result stage.
// Depends on mrbmv_pkg, mrbmv_chan_if and mrbmv_vote.
//
// channel  modport  word                                   use
// cfg      sink     revisions_in_use (5 b)                  revolutions voting
// bits     sink     revision_bits (16 b), last_position     one bit position
// vote     source   majority, weak flag, three counts, done one result per position
//
// One word in and one word out per cycle when vote is ready, via input and result stage.
// Ready reaches back through both stages, so a word is taken while a result waits if the input stage is empty.
// Reset clears both stages, the counters and sets revisions_in_use to 1.
// A stall on vote holds the result and the input stage; counters move only on advance.
`default_nettype none

module multi_read_bit_majority_voter #(
    parameter int MAX_REVOLUTIONS = mrbmv_pkg::MAX_REVOLUTIONS_DEF,
    parameter int COUNT_WIDTH     = mrbmv_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mrbmv_chan_if.sink    cfg,
    mrbmv_chan_if.sink    bits,
    mrbmv_chan_if.source  vote
);

    localparam int OUT_W = mrbmv_pkg::COUNT_FIELD_W;

    mrbmv_pkg::cfg_word_t         revs_reg;
    logic                         s1_valid_reg;
    logic [mrbmv_pkg::BITS_W-1:0] s1_bits_reg;
    logic                         s1_last_reg;
    logic                         out_valid_reg;
    mrbmv_pkg::out_word_t         out_word_reg;
    mrbmv_pkg::out_word_t         out_word_next;
    logic [COUNT_WIDTH-1:0]       pos_cnt_reg;
    logic [COUNT_WIDTH-1:0]       agree_cnt_reg;
    logic [COUNT_WIDTH-1:0]       dis_cnt_reg;
    logic [COUNT_WIDTH-1:0]       pos_cnt_next;
    logic [COUNT_WIDTH-1:0]       agree_cnt_next;
    logic [COUNT_WIDTH-1:0]       dis_cnt_next;
    logic [COUNT_WIDTH-1:0]       pos_inc;
    logic [COUNT_WIDTH-1:0]       agree_inc;
    logic [COUNT_WIDTH-1:0]       dis_inc;
    logic                         out_free;
    logic                         s1_adv;
    mrbmv_pkg::vote_t             vote_res;

    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || vote.ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign bits.ready = !s1_valid_reg || out_free;

    assign vote.valid   = out_valid_reg;
    assign vote.payload = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revs_reg <= mrbmv_pkg::CFG_RESET;
        end
        else if (cfg.valid)
        begin
            revs_reg <= cfg.payload;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bits.ready)
        begin
            s1_valid_reg <= bits.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bits.valid && bits.ready)
        begin
            s1_bits_reg <= bits.payload.revision_bits;
            s1_last_reg <= bits.payload.last_position;
        end
    end

    mrbmv_vote #(
        .MAX_REVOLUTIONS (MAX_REVOLUTIONS)
    ) u_vote (
        .revision_bits    (s1_bits_reg),
        .revisions_in_use (revs_reg),
        .vote             (vote_res)
    );

    assign pos_inc   = (pos_cnt_reg   == '1) ? pos_cnt_reg   : pos_cnt_reg   + 1'b1;
    assign agree_inc = (agree_cnt_reg == '1) ? agree_cnt_reg : agree_cnt_reg + 1'b1;
    assign dis_inc   = (dis_cnt_reg   == '1) ? dis_cnt_reg   : dis_cnt_reg   + 1'b1;

    always_comb
    begin
        out_word_next.majority_bit    = vote_res.majority;
        out_word_next.weak_flag       = vote_res.disagree;
        out_word_next.bits_seen       = OUT_W'(pos_inc);
        out_word_next.unanimous_count = vote_res.disagree ? OUT_W'(agree_cnt_reg)
                                                          : OUT_W'(agree_inc);
        out_word_next.weak_count      = vote_res.disagree ? OUT_W'(dis_inc)
                                                          : OUT_W'(dis_cnt_reg);
        out_word_next.track_done      = s1_last_reg;
    end

    // count on each advance but the last; clear after the track's last position
    always_comb
    begin
        pos_cnt_next   = pos_cnt_reg;
        agree_cnt_next = agree_cnt_reg;
        dis_cnt_next   = dis_cnt_reg;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                pos_cnt_next   = '0;
                agree_cnt_next = '0;
                dis_cnt_next   = '0;
            end
            else
            begin
                pos_cnt_next   = pos_inc;
                agree_cnt_next = vote_res.disagree ? agree_cnt_reg : agree_inc;
                dis_cnt_next   = vote_res.disagree ? dis_inc : dis_cnt_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cnt_reg   <= '0;
            agree_cnt_reg <= '0;
            dis_cnt_reg   <= '0;
        end
        else
        begin
            pos_cnt_reg   <= pos_cnt_next;
            agree_cnt_reg <= agree_cnt_next;
            dis_cnt_reg   <= dis_cnt_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_word_reg <= out_word_next;
        end
    end

    a_clear_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> (pos_cnt_reg == '0) && (agree_cnt_reg == '0)
                                  && (dis_cnt_reg == '0)
    ) else $error("counters not cleared after last position");

    a_count_moves: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_last_reg |=> pos_cnt_reg != '0
    ) else $error("position count zero after a position");

    a_hold_counts: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(pos_cnt_reg) && $stable(agree_cnt_reg) && $stable(dis_cnt_reg)
    ) else $error("counters changed without an advance");

    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> bits.ready
    ) else $error("input blocked with empty result stage");

endmodule

`default_nettype wire
